// ===== rtl/kst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int STEP_W       = 20;
  localparam int COUNT_W      = 7;

  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_PUSH  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_SLOT  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;

  typedef struct packed {
    logic [31:0]        id;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] strength;
  } slot_t;

  typedef struct packed {
    logic               valid;
    logic [31:0]        id;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] strength;
    logic [31:0]        age;
  } rep_t;

  typedef struct packed {
    logic valid;
    logic match_found;
    logic free_found;
  } sw_t;

  typedef struct packed {
    logic              age_en;
    logic              clr;
    logic              load;
    logic              shift;
    logic              wr_en;
    logic [STEP_W-1:0] step;
    slot_t             wr_data;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/kst_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kst_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire kst_pkg::ctrl_t ctrl,
  input  wire logic [IW-1:0]  wr_idx,
  input  wire kst_pkg::sw_t   sw_in,
  input  wire logic [IW-1:0]  match_idx_in,
  input  wire logic [IW-1:0]  free_idx_in,
  output kst_pkg::sw_t        sw_out,
  output logic [IW-1:0]       match_idx_out,
  output logic [IW-1:0]       free_idx_out,
  input  wire kst_pkg::rep_t  rep_in,
  output kst_pkg::rep_t       rep_out
);

  logic                used;
  kst_pkg::slot_t      slot;
  logic [31:0]         age;
  logic                wr_hit;
  logic                id_hit;
  logic [32:0]         age_sum;
  logic [31:0]         age_sat;
  kst_pkg::sw_t        sw_next;
  logic [IW-1:0]       match_idx_next;
  logic [IW-1:0]       free_idx_next;

  assign wr_hit  = ctrl.wr_en && (wr_idx == IW'(IDX));
  assign age_sum = {1'b0, age} + {{(33 - kst_pkg::STEP_W){1'b0}}, ctrl.step};
  assign age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
  assign id_hit  = used && (slot.id == ctrl.wr_data.id);

  // search word moves one cell per cycle, first hit and first free slot win
  always_comb begin
    sw_next.valid       = sw_in.valid;
    sw_next.match_found = sw_in.match_found || id_hit;
    sw_next.free_found  = sw_in.free_found || !used;
    match_idx_next      = sw_in.match_found ? match_idx_in : IW'(IDX);
    free_idx_next       = sw_in.free_found ? free_idx_in : IW'(IDX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctrl.clr) begin
      used <= 1'b0;
    end else if (wr_hit) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      slot <= ctrl.wr_data;
      age  <= '0;
    end else if (ctrl.age_en && used) begin
      age <= age_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_out <= '0;
    end else begin
      sw_out <= sw_next;
    end
    match_idx_out <= match_idx_next;
    free_idx_out  <= free_idx_next;
  end

  // report line, loaded from the slots and shifted towards cell zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_out <= '0;
    end else if (ctrl.load) begin
      rep_out.valid    <= used;
      rep_out.id       <= slot.id;
      rep_out.x        <= slot.x;
      rep_out.y        <= slot.y;
      rep_out.strength <= slot.strength;
      rep_out.age      <= age;
    end else if (ctrl.shift) begin
      rep_out <= rep_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/keyed_slot_table_with_aging.sv =====
// Keyed slot table with aging. A begin word (action 0) or an unused action
// code is taken and busy stays low. A push word (action 1) sends a search
// word down the row of CAPACITY cells, one cell per cycle; its status
// result is registered when the search word leaves the last cell, and busy
// stays high until that result appears. An end word (action 2) loads the report
// line and shifts it out of cell zero one slot per cycle: one result per used
// slot in slot order, busy until the last used slot is out, or a single
// empty report in the cycle after acceptance with busy staying low. Results
// are marked by valid for exactly one cycle and cannot be stalled; the
// receiver must take every word as it comes.
`timescale 1ns / 1ps
`default_nettype none

module keyed_slot_table_with_aging #(
  parameter int CAPACITY = kst_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  action,
  input  wire logic [31:0]                 point_id,
  input  wire logic signed [15:0]          pos_x,
  input  wire logic signed [15:0]          pos_y,
  input  wire logic signed [15:0]          strength,
  input  wire logic [kst_pkg::STEP_W-1:0]  step_time_us,
  input  wire logic                        clear_first,
  output logic                             valid,
  output logic [1:0]                       kind,
  output logic [1:0]                       push_status,
  output logic [31:0]                      point_id_res,
  output logic signed [15:0]               pos_x_res,
  output logic signed [15:0]               pos_y_res,
  output logic signed [15:0]               strength_res,
  output logic [31:0]                      age_us,
  output logic [31:0]                      quiet_time_us,
  output logic [kst_pkg::COUNT_W-1:0]      entry_count,
  output logic                             last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    REPORT
  } state_t;

  state_t                   state;
  logic                     inject;
  kst_pkg::slot_t           probe;
  logic [kst_pkg::STEP_W-1:0] frame_step;
  logic [31:0]              quiet;
  logic                     activity;
  logic [CW-1:0]            count;
  logic [CW-1:0]            emitted;

  logic                     accept;
  kst_pkg::ctrl_t           ctrl;
  logic [IW-1:0]            wr_idx;
  logic [32:0]              quiet_sum;
  logic [31:0]              quiet_next;
  logic                     emit_last;

  kst_pkg::sw_t             sw [0:CAPACITY];
  logic [IW-1:0]            match_idx [0:CAPACITY];
  logic [IW-1:0]            free_idx [0:CAPACITY];
  kst_pkg::rep_t            rep [0:CAPACITY];

  assign busy   = (state != IDLE);
  assign accept = start && !busy;

  assign sw[0].valid       = inject;
  assign sw[0].match_found = 1'b0;
  assign sw[0].free_found  = 1'b0;
  assign match_idx[0]      = '0;
  assign free_idx[0]       = '0;
  assign rep[CAPACITY]     = '0;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      kst_cell #(
        .IW  (IW),
        .IDX (gi)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .ctrl          (ctrl),
        .wr_idx        (wr_idx),
        .sw_in         (sw[gi]),
        .match_idx_in  (match_idx[gi]),
        .free_idx_in   (free_idx[gi]),
        .sw_out        (sw[gi+1]),
        .match_idx_out (match_idx[gi+1]),
        .free_idx_out  (free_idx[gi+1]),
        .rep_in        (rep[gi+1]),
        .rep_out       (rep[gi])
      );
    end
  endgenerate

  assign quiet_sum  = {1'b0, quiet} + {{(33 - kst_pkg::STEP_W){1'b0}}, frame_step};
  assign quiet_next = activity ? 32'd0 : (quiet_sum[32] ? 32'hFFFF_FFFF : quiet_sum[31:0]);
  assign emit_last  = ((emitted + CW'(1)) == count);
  assign wr_idx     = sw[CAPACITY].match_found ? match_idx[CAPACITY] : free_idx[CAPACITY];

  always_comb begin
    ctrl.age_en  = accept && (action == kst_pkg::ACT_BEGIN);
    ctrl.clr     = accept && (action == kst_pkg::ACT_BEGIN) && clear_first;
    ctrl.load    = accept && (action == kst_pkg::ACT_END) && (count != '0);
    ctrl.shift   = (state == REPORT);
    ctrl.wr_en   = (state == SEARCH) && sw[CAPACITY].valid &&
                   (sw[CAPACITY].match_found || sw[CAPACITY].free_found);
    ctrl.step    = step_time_us;
    ctrl.wr_data = probe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      inject     <= 1'b0;
      frame_step <= '0;
      quiet      <= '0;
      activity   <= 1'b0;
      count      <= '0;
      emitted    <= '0;
      valid      <= 1'b0;
    end else begin
      inject <= 1'b0;
      valid  <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            case (action)
              kst_pkg::ACT_BEGIN: begin
                frame_step <= step_time_us;
                if (clear_first) begin
                  count    <= '0;
                  activity <= 1'b1;
                end
              end
              kst_pkg::ACT_PUSH: begin
                probe.id       <= point_id;
                probe.x        <= pos_x;
                probe.y        <= pos_y;
                probe.strength <= strength;
                inject         <= 1'b1;
                state          <= SEARCH;
              end
              kst_pkg::ACT_END: begin
                quiet    <= quiet_next;
                activity <= 1'b0;
                emitted  <= '0;
                if (count == '0) begin
                  valid         <= 1'b1;
                  kind          <= kst_pkg::KIND_EMPTY;
                  push_status   <= kst_pkg::ST_UPDATED;
                  point_id_res  <= '0;
                  pos_x_res     <= '0;
                  pos_y_res     <= '0;
                  strength_res  <= '0;
                  age_us        <= '0;
                  quiet_time_us <= quiet_next;
                  entry_count   <= '0;
                  last          <= 1'b1;
                end else begin
                  state <= REPORT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        SEARCH: begin
          if (sw[CAPACITY].valid) begin
            valid         <= 1'b1;
            kind          <= kst_pkg::KIND_PUSH;
            point_id_res  <= probe.id;
            pos_x_res     <= '0;
            pos_y_res     <= '0;
            strength_res  <= '0;
            age_us        <= '0;
            quiet_time_us <= '0;
            entry_count   <= '0;
            last          <= 1'b1;
            activity      <= 1'b1;
            if (sw[CAPACITY].match_found) begin
              push_status <= kst_pkg::ST_UPDATED;
            end else if (sw[CAPACITY].free_found) begin
              push_status <= kst_pkg::ST_INSERTED;
              count       <= count + CW'(1);
            end else begin
              push_status <= kst_pkg::ST_DROPPED;
            end
            state <= IDLE;
          end
        end
        REPORT: begin
          if (rep[0].valid) begin
            valid         <= 1'b1;
            kind          <= kst_pkg::KIND_SLOT;
            push_status   <= kst_pkg::ST_UPDATED;
            point_id_res  <= rep[0].id;
            pos_x_res     <= rep[0].x;
            pos_y_res     <= rep[0].y;
            strength_res  <= rep[0].strength;
            age_us        <= rep[0].age;
            quiet_time_us <= quiet;
            entry_count   <= kst_pkg::COUNT_W'(count);
            last          <= emit_last;
            emitted       <= emitted + CW'(1);
            if (emit_last) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_search_gives_status: assert property (@(posedge clk) disable iff (rst)
    (state == SEARCH && sw[CAPACITY].valid) |=> (valid && kind == kst_pkg::KIND_PUSH && last))
    else $error("search word left the row without a push status");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(CAPACITY)))
    else $error("used slot count beyond capacity");

  a_last_slot_frees: assert property (@(posedge clk) disable iff (rst)
    (valid && kind == kst_pkg::KIND_SLOT && last) |-> !busy)
    else $error("still busy after final slot report");

  a_report_in_order: assert property (@(posedge clk) disable iff (rst)
    (state == REPORT && rep[0].valid && !emit_last) |=> (state == REPORT))
    else $error("report ended before all used slots were sent");

endmodule

`default_nettype wire

// ===== bench/keyed_slot_table_scoreboard.sv =====
`timescale 1ns / 1ps

module keyed_slot_table_scoreboard #(
  parameter int CAPACITY = kst_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 action,
  input  logic [31:0]                point_id,
  input  logic [15:0]                pos_x,
  input  logic [15:0]                pos_y,
  input  logic [15:0]                strength,
  input  logic [kst_pkg::STEP_W-1:0] step_time_us,
  input  logic                       clear_first,
  input  logic                       valid,
  input  logic [1:0]                 kind,
  input  logic [1:0]                 push_status,
  input  logic [31:0]                point_id_res,
  input  logic [15:0]                pos_x_res,
  input  logic [15:0]                pos_y_res,
  input  logic [15:0]                strength_res,
  input  logic [31:0]                age_us,
  input  logic [31:0]                quiet_time_us,
  input  logic [kst_pkg::COUNT_W-1:0] entry_count,
  input  logic                       last,
  output int                         fail_count,
  output int                         outstanding,
  output int                         words_in,
  output int                         words_out,
  output int                         drops
);
  import kst_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         status;
    logic [31:0]        id;
    logic [15:0]        x;
    logic [15:0]        y;
    logic [15:0]        str;
    logic [31:0]        age;
    logic [31:0]        quiet;
    logic [COUNT_W-1:0] count;
    logic               last;
  } report_t;

  logic [CAPACITY-1:0] tbl_used;
  logic [31:0]         tbl_id  [CAPACITY];
  logic [15:0]         tbl_x   [CAPACITY];
  logic [15:0]         tbl_y   [CAPACITY];
  logic [15:0]         tbl_str [CAPACITY];
  logic [31:0]         tbl_age [CAPACITY];
  logic [31:0]         quiet_us;
  logic [STEP_W-1:0]   step_us;
  logic                activity;
  report_t             expected_q[$];

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic check_word();
    report_t w;
    words_out++;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result word with nothing expected: kind %0d id %h", kind, point_id_res);
    end else begin
      w = expected_q.pop_front();
      field_check("kind", w.kind, kind);
      field_check("push_status", w.status, push_status);
      field_check("point_id_res", w.id, point_id_res);
      field_check("pos_x_res", w.x, pos_x_res);
      field_check("pos_y_res", w.y, pos_y_res);
      field_check("strength_res", w.str, strength_res);
      field_check("age_us", w.age, age_us);
      field_check("quiet_time_us", w.quiet, quiet_time_us);
      field_check("entry_count", w.count, entry_count);
      field_check("last", w.last, last);
    end
  endtask

  task automatic predict_word();
    int      i;
    int      hit;
    int      n;
    int      k;
    report_t r;
    hit = -1;
    n = 0;
    k = 0;
    r = '0;
    words_in++;
    case (action)
      ACT_BEGIN: begin
        step_us = step_time_us;
        for (i = 0; i < CAPACITY; i++)
          if (tbl_used[i]) tbl_age[i] = sat_add(tbl_age[i], 32'(step_us));
        if (clear_first) begin
          tbl_used = '0;
          activity = 1'b1;
        end
      end
      ACT_PUSH: begin
        for (i = 0; i < CAPACITY; i++)
          if (hit < 0 && tbl_used[i] && tbl_id[i] == point_id) hit = i;
        if (hit >= 0) begin
          r.status = ST_UPDATED;
        end else begin
          for (i = 0; i < CAPACITY; i++)
            if (hit < 0 && !tbl_used[i]) hit = i;
          r.status = (hit >= 0) ? ST_INSERTED : ST_DROPPED;
        end
        if (hit >= 0) begin
          tbl_id[hit]   = point_id;
          tbl_x[hit]    = pos_x;
          tbl_y[hit]    = pos_y;
          tbl_str[hit]  = strength;
          tbl_age[hit]  = '0;
          tbl_used[hit] = 1'b1;
        end else begin
          drops++;
        end
        activity = 1'b1;
        r.kind = KIND_PUSH;
        r.id   = point_id;
        r.last = 1'b1;
        expected_q = {expected_q, r};
      end
      ACT_END: begin
        quiet_us = activity ? '0 : sat_add(quiet_us, 32'(step_us));
        activity = 1'b0;
        for (i = 0; i < CAPACITY; i++)
          if (tbl_used[i]) n++;
        if (n == 0) begin
          r.kind  = KIND_EMPTY;
          r.quiet = quiet_us;
          r.last  = 1'b1;
          expected_q = {expected_q, r};
        end else begin
          for (i = 0; i < CAPACITY; i++) begin
            if (tbl_used[i]) begin
              k++;
              r       = '0;
              r.kind  = KIND_SLOT;
              r.id    = tbl_id[i];
              r.x     = tbl_x[i];
              r.y     = tbl_y[i];
              r.str   = tbl_str[i];
              r.age   = tbl_age[i];
              r.quiet = quiet_us;
              r.count = COUNT_W'(n);
              r.last  = (k == n);
              expected_q = {expected_q, r};
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tbl_used = '0;
      quiet_us = '0;
      step_us  = '0;
      activity = 1'b0;
      expected_q.delete();
      fail_count  = 0;
      words_in    = 0;
      words_out   = 0;
      drops       = 0;
      outstanding = 0;
    end else begin
      // results belong to earlier words, so check before predicting
      if (valid) check_word();
      if (start && !busy) predict_word();
      outstanding = expected_q.size();
    end
  end

endmodule

// ===== bench/keyed_slot_table_with_aging_tb.sv =====
`timescale 1ns / 1ps

module keyed_slot_table_with_aging_tb;
  import kst_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_WORDS = 250;
  localparam int QUIET_TAIL   = 50;
  localparam int POOL         = 24;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          action;
  logic [31:0]         point_id;
  logic signed [15:0]  pos_x;
  logic signed [15:0]  pos_y;
  logic signed [15:0]  strength;
  logic [STEP_W-1:0]   step_time_us;
  logic                clear_first;
  logic                valid;
  logic [1:0]          kind;
  logic [1:0]          push_status;
  logic [31:0]         point_id_res;
  logic signed [15:0]  pos_x_res;
  logic signed [15:0]  pos_y_res;
  logic signed [15:0]  strength_res;
  logic [31:0]         age_us;
  logic [31:0]         quiet_time_us;
  logic [COUNT_W-1:0]  entry_count;
  logic                last;

  int          fail_count;
  int          outstanding;
  int          words_in;
  int          words_out;
  int          drops;
  int          stall_cycles;
  int          words_sent;
  bit          pauses_on;
  logic [31:0] id_pool [POOL];

  keyed_slot_table_with_aging #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .point_id(point_id), .pos_x(pos_x), .pos_y(pos_y),
    .strength(strength), .step_time_us(step_time_us), .clear_first(clear_first),
    .valid(valid), .kind(kind), .push_status(push_status),
    .point_id_res(point_id_res), .pos_x_res(pos_x_res), .pos_y_res(pos_y_res),
    .strength_res(strength_res), .age_us(age_us), .quiet_time_us(quiet_time_us),
    .entry_count(entry_count), .last(last)
  );

  keyed_slot_table_scoreboard #(.CAPACITY(CAPACITY)) u_score (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .point_id(point_id), .pos_x(pos_x), .pos_y(pos_y),
    .strength(strength), .step_time_us(step_time_us), .clear_first(clear_first),
    .valid(valid), .kind(kind), .push_status(push_status),
    .point_id_res(point_id_res), .pos_x_res(pos_x_res), .pos_y_res(pos_y_res),
    .strength_res(strength_res), .age_us(age_us), .quiet_time_us(quiet_time_us),
    .entry_count(entry_count), .last(last),
    .fail_count(fail_count), .outstanding(outstanding),
    .words_in(words_in), .words_out(words_out), .drops(drops)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // word is held on the ports until taken
  task automatic send_word(logic [1:0] act, logic [31:0] id, logic [15:0] x,
                           logic [15:0] y, logic [15:0] s,
                           logic [STEP_W-1:0] step, logic clr);
    if (pauses_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start        <= 1'b1;
    action       <= act;
    point_id     <= id;
    pos_x        <= x;
    pos_y        <= y;
    strength     <= s;
    step_time_us <= step;
    clear_first  <= clr;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act != ACT_UNUSED) words_sent++;
  endtask

  task automatic begin_frame(logic [STEP_W-1:0] step, logic clr);
    send_word(ACT_BEGIN, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
              step, clr);
  endtask

  task automatic push_point(logic [31:0] id, logic [15:0] x, logic [15:0] y,
                            logic [15:0] s);
    send_word(ACT_PUSH, id, x, y, s, STEP_W'($urandom), 1'($urandom));
  endtask

  task automatic end_frame();
    send_word(ACT_END, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
              STEP_W'($urandom), 1'($urandom));
  endtask

  initial begin
    int                i;
    int                npush;
    int                pick;
    logic [STEP_W-1:0] step;
    logic [31:0]       id;
    rst          <= 1'b1;
    start        <= 1'b0;
    action       <= ACT_BEGIN;
    point_id     <= '0;
    pos_x        <= '0;
    pos_y        <= '0;
    strength     <= '0;
    step_time_us <= '0;
    clear_first  <= 1'b0;
    words_sent = 0;
    pauses_on  = 1'b1;
    for (i = 0; i < POOL; i++) id_pool[i] = $urandom;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // short directed pass over the corners
    end_frame();
    send_word(ACT_UNUSED, '1, '1, '1, '1, '1, 1'b1);
    begin_frame('0, 1'b0);
    push_point(32'h0000_0000, 16'h8000, 16'h7FFF, 16'hFFFF);
    push_point(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h0000);
    push_point(32'h0000_0000, 16'h0001, 16'hFFFE, 16'h8000);
    end_frame();
    begin_frame(20'hFFFFF, 1'b0);
    end_frame();
    begin_frame(20'd1000000, 1'b1);
    end_frame();
    begin_frame(20'd7, 1'b0);
    for (i = 0; i <= CAPACITY; i++)
      push_point(32'h100 + i, 16'($urandom), 16'($urandom), 16'($urandom));
    push_point(32'h105, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    end_frame();

    // random frames, mostly well formed, some loose words
    pauses_on = 1'b1;
    begin_frame(STEP_W'($urandom_range(0, 100)), 1'b1);
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      pauses_on = (words_sent < RANDOM_WORDS - QUIET_TAIL);
      if ($urandom_range(0, 6) == 0) begin
        send_word(2'($urandom_range(0, 3)), $urandom, 16'($urandom), 16'($urandom),
                  16'($urandom), STEP_W'($urandom), 1'($urandom));
      end else begin
        pick = $urandom_range(0, 9);
        step = (pick == 0) ? '0 :
               (pick == 1) ? 20'hFFFFF :
               (pick == 2) ? STEP_W'($urandom) : STEP_W'($urandom_range(1, 50000));
        begin_frame(step, $urandom_range(0, 7) == 0);
        npush = $urandom_range(0, 20);
        for (i = 0; i < npush; i++) begin
          id = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, POOL - 1)];
          push_point(id, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        end_frame();
      end
    end
    start <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (CAPACITY + 4) @(posedge clk);
    $display("covered %0d input words and %0d result words, %0d pushes dropped on a full table,",
             words_in, words_out, drops);
    $display("with table fills, clears, loose words, id corners and full-scale frame steps");
    if (fail_count == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
